/* rtl/dsd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsd_pkg
// Shared widths, codes and controller/datapath interface types for the
// decimal stream divider.
// ----------------------------------------------------------------------------
package dsd_pkg;

	// Field and register widths
	localparam int DIGIT_W    = 4;   // one decimal digit
	localparam int DIV_W      = 16;  // divisor and remainder
	localparam int QUOT_W     = 4;   // one quotient digit, at most nine
	localparam int T_W        = 20;  // remainder times ten plus a digit
	localparam int TDATA_W    = 8;   // digit padded to a whole byte

	localparam int FRACTION_DIGITS_DEF = 5;

	localparam logic [DIGIT_W-1:0] MAX_DIGIT   = 4'd9;
	localparam logic [DIV_W-1:0]   DIVISOR_RST = 16'd1;

	// Result kinds carried on tuser
	localparam logic KIND_DIGIT = 1'b0;
	localparam logic KIND_POINT = 1'b1;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load_in;     // t = remainder * 10 + input digit
		logic load_frac;   // t = remainder * 10
		logic step;        // one restoring division step
		logic emit;        // load the output register
		logic emit_point;  // the emitted symbol is the point
		logic emit_end;    // the emitted symbol ends the number
		logic set_seen;    // a quotient digit has gone out
		logic clear;       // drop remainder and seen flag
	} dsd_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic quot_nz;
		logic rem_zero;
		logic seen;
		logic last;
		logic out_free;
	} dsd_sts_t;

endpackage

/* rtl/dsd_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsd_datapath
// Divisor register, running remainder, one-bit-a-cycle restoring divider for
// a single quotient digit, and the output register.
// ----------------------------------------------------------------------------
module dsd_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_we,
	input  logic [dsd_pkg::DIV_W-1:0]     cfg_data,
	// input item
	input  logic [dsd_pkg::DIGIT_W-1:0]   in_digit,
	input  logic                          in_last,
	// control
	input  dsd_pkg::dsd_cmd_t             cmd,
	output dsd_pkg::dsd_sts_t             sts,
	// output stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [dsd_pkg::TDATA_W-1:0]   m_tdata,
	output logic                          m_tuser,
	output logic                          m_tlast
);

	localparam int DIV_W   = dsd_pkg::DIV_W;
	localparam int T_W     = dsd_pkg::T_W;
	localparam int QUOT_W  = dsd_pkg::QUOT_W;
	localparam int DIGIT_W = dsd_pkg::DIGIT_W;
	localparam int TDATA_W = dsd_pkg::TDATA_W;

	logic [DIV_W-1:0]   div_q;
	logic [T_W-1:0]     t_q;      // low bits hold the remainder between divisions
	logic [T_W-1:0]     dsh_q;    // divisor aligned to the current quotient bit
	logic [QUOT_W-1:0]  quot_q;
	logic               seen_q;
	logic               last_q;
	logic               m_tvalid_q;
	logic [QUOT_W-1:0]  m_digit_q;
	logic               m_kind_q;
	logic               m_end_q;

	logic [DIV_W-1:0]   div_eff;
	logic [DIV_W-1:0]   rem;
	logic [DIGIT_W-1:0] digit_sat;
	logic [T_W-1:0]     rem_x10;
	logic               ge;
	logic               out_free;

	// Treat a zero divisor as one, saturate digits above nine
	assign div_eff   = (div_q == '0) ? dsd_pkg::DIVISOR_RST : div_q;
	assign digit_sat = (in_digit > dsd_pkg::MAX_DIGIT) ? dsd_pkg::MAX_DIGIT : in_digit;
	assign rem       = t_q[DIV_W-1:0];
	assign rem_x10   = T_W'({rem, 3'b000}) + T_W'({rem, 1'b0});
	assign ge        = (t_q >= dsh_q);
	assign out_free  = !m_tvalid_q || m_tready;

	// Divisor register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q <= dsd_pkg::DIVISOR_RST;
		end else if (cfg_we) begin
			div_q <= cfg_data;
		end
	end

	// Remainder, divider and per-number flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_q    <= '0;
			seen_q <= 1'b0;
			last_q <= 1'b0;
		end else begin
			if (cfg_we || cmd.clear) begin
				t_q <= '0;
			end else if (cmd.load_in) begin
				t_q <= rem_x10 + T_W'(digit_sat);
			end else if (cmd.load_frac) begin
				t_q <= rem_x10;
			end else if (cmd.step && ge) begin
				t_q <= t_q - dsh_q;
			end
			if (cfg_we || cmd.clear) begin
				seen_q <= 1'b0;
			end else if (cmd.set_seen) begin
				seen_q <= 1'b1;
			end
			if (cmd.load_in) begin
				last_q <= in_last;
			end
		end
	end

	// Shifted divisor and quotient bits
	always_ff @(posedge clk) begin
		if (cmd.load_in || cmd.load_frac) begin
			dsh_q  <= T_W'({div_eff, {(QUOT_W-1){1'b0}}});
			quot_q <= '0;
		end else if (cmd.step) begin
			dsh_q  <= dsh_q >> 1;
			quot_q <= {quot_q[QUOT_W-2:0], ge};
		end
	end

	// Output register: hold until the transfer, reload when emitting
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			m_digit_q <= cmd.emit_point ? '0 : quot_q;
			m_kind_q  <= cmd.emit_point ? dsd_pkg::KIND_POINT : dsd_pkg::KIND_DIGIT;
			m_end_q   <= cmd.emit_end;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = TDATA_W'(m_digit_q);
	assign m_tuser  = m_kind_q;
	assign m_tlast  = m_end_q;

	// Status back to the controller
	always_comb begin
		sts          = '0;
		sts.quot_nz  = (quot_q != '0);
		sts.rem_zero = (rem == '0);
		sts.seen     = seen_q;
		sts.last     = last_q;
		sts.out_free = out_free;
	end

endmodule

/* rtl/dsd_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsd_ctrl
// Sequencer for one input digit: divide, emit the integer digit unless it is a
// leading zero, then on the last digit emit the point and the fraction digits.
// ----------------------------------------------------------------------------
module dsd_ctrl #(
	parameter int FRACTION_DIGITS = dsd_pkg::FRACTION_DIGITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 cfg_ready,
	input  dsd_pkg::dsd_sts_t    sts,
	output dsd_pkg::dsd_cmd_t    cmd
);

	localparam int FCNT_W  = ($clog2(FRACTION_DIGITS + 1) > 0) ? $clog2(FRACTION_DIGITS + 1) : 1;
	localparam int STEP_W  = $clog2(dsd_pkg::QUOT_W);
	localparam bit NO_FRAC = (FRACTION_DIGITS == 0);
	localparam logic [STEP_W-1:0] STEP_FIRST = STEP_W'(dsd_pkg::QUOT_W - 1);
	localparam logic [FCNT_W-1:0] FRAC_LAST  = FCNT_W'(FRACTION_DIGITS - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT_INT,
		ST_EMIT_PT,
		ST_EMIT_FRAC
	} state_t;

	state_t            state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;
	logic [FCNT_W-1:0] frac_cnt_q, frac_cnt_d;
	logic              frac_q, frac_d;

	// Next state and commands
	always_comb begin
		state_d    = state_q;
		step_d     = step_q;
		frac_cnt_d = frac_cnt_q;
		frac_d     = frac_q;
		cmd        = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					step_d      = STEP_FIRST;
					frac_d      = 1'b0;
					state_d     = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				step_d   = step_q - 1'b1;
				if (step_q == '0) begin
					state_d = frac_q ? ST_EMIT_FRAC : ST_EMIT_INT;
				end
			end
			ST_EMIT_INT: begin
				if (sts.quot_nz || sts.seen) begin
					// digit goes out, wait for room in the output register
					if (sts.out_free) begin
						cmd.emit     = 1'b1;
						cmd.set_seen = 1'b1;
						state_d      = sts.last ? ST_EMIT_PT : ST_IDLE;
					end
				end else begin
					state_d = sts.last ? ST_EMIT_PT : ST_IDLE;
				end
			end
			ST_EMIT_PT: begin
				if (sts.out_free) begin
					cmd.emit       = 1'b1;
					cmd.emit_point = 1'b1;
					if (sts.rem_zero || NO_FRAC) begin
						cmd.emit_end = 1'b1;
						cmd.clear    = 1'b1;
						state_d      = ST_IDLE;
					end else begin
						cmd.load_frac = 1'b1;
						step_d        = STEP_FIRST;
						frac_cnt_d    = '0;
						frac_d        = 1'b1;
						state_d       = ST_DIV;
					end
				end
			end
			ST_EMIT_FRAC: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.rem_zero || (frac_cnt_q == FRAC_LAST)) begin
						cmd.emit_end = 1'b1;
						cmd.clear    = 1'b1;
						state_d      = ST_IDLE;
					end else begin
						cmd.load_frac = 1'b1;
						step_d        = STEP_FIRST;
						frac_cnt_d    = frac_cnt_q + 1'b1;
						state_d       = ST_DIV;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			step_q     <= '0;
			frac_cnt_q <= '0;
			frac_q     <= 1'b0;
		end else begin
			state_q    <= state_d;
			step_q     <= step_d;
			frac_cnt_q <= frac_cnt_d;
			frac_q     <= frac_d;
		end
	end

	// An offered digit wins over a divisor write in the same cycle
	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE) && !in_valid;

endmodule

/* rtl/decimal_stream_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_stream_divider
// Streaming long division of a decimal number by a configured integer.
// ----------------------------------------------------------------------------
// Digits arrive most significant first on the slave stream, s_tlast marking
// the final integer digit; each digit is divided into the running remainder
// by a restoring divider that finds one quotient bit per cycle, so an input
// digit passes through accept, 4 divide steps and emit, and the last digit
// adds the point plus, per fraction digit, up to FRACTION_DIGITS of them,
// 4 divide steps and an emit, each emit waiting while the consumer stalls.
// Leading zero quotient digits are dropped, so 3/7 starts with the point.
// A divisor write also clears the remainder; a zero divisor acts as one.
// ----------------------------------------------------------------------------
module decimal_stream_divider #(
	parameter int FRACTION_DIGITS = dsd_pkg::FRACTION_DIGITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// divisor write channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [dsd_pkg::DIV_W-1:0]     cfg_data,
	// input digits
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [dsd_pkg::TDATA_W-1:0]   s_tdata,   // [3:0] digit, [7:4] zero
	input  logic                          s_tlast,   // is_last
	// result symbols
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [dsd_pkg::TDATA_W-1:0]   m_tdata,   // [3:0] digit_value, [7:4] zero
	output logic                          m_tuser,   // [0] symbol_kind
	output logic                          m_tlast    // end_of_number
);

	dsd_pkg::dsd_cmd_t cmd;
	dsd_pkg::dsd_sts_t sts;
	logic              cfg_we;

	assign cfg_we = cfg_valid && cfg_ready;

	dsd_ctrl #(
		.FRACTION_DIGITS (FRACTION_DIGITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.cfg_ready (cfg_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	dsd_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.in_digit (s_tdata[dsd_pkg::DIGIT_W-1:0]),
		.in_last  (s_tlast),
		.cmd      (cmd),
		.sts      (sts),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

/* rtl/dsd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsd_checker
// Port-level checks on the decimal stream divider, bound to the top level.
// ----------------------------------------------------------------------------
module dsd_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [dsd_pkg::TDATA_W-1:0]   m_tdata,
	input logic                          m_tuser,
	input logic                          m_tlast
);

	// Stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result changed while stalled");

	// A point carries a zero digit value
	a_point_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == dsd_pkg::KIND_POINT) |-> m_tdata == '0)
		else $error("point with nonzero digit value");

	// A quotient digit stays decimal
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == dsd_pkg::KIND_DIGIT) |->
			m_tdata <= dsd_pkg::TDATA_W'(dsd_pkg::MAX_DIGIT))
		else $error("quotient digit above nine");

	// The divider is busy right after an input transfer
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while a digit is being divided");

endmodule

bind decimal_stream_divider dsd_checker u_dsd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
